>>> hw/rtl/mvl_pkg.sv
package mvl_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_BUSY    = 2'd0,
		ST_NOSYNC  = 2'd1,
		ST_BADCRC  = 2'd2,
		ST_DONE    = 2'd3
	} mvl_status_t;

	// role of one byte within the frame, decided by the front end
	typedef enum logic [2:0] {
		KIND_IDLE    = 3'd0,
		KIND_LEN     = 3'd1,
		KIND_SEQ     = 3'd2,
		KIND_SYS     = 3'd3,
		KIND_COMP    = 3'd4,
		KIND_MSG     = 3'd5,
		KIND_PAYLOAD = 3'd6,
		KIND_CHECK   = 3'd7
	} mvl_kind_t;

	localparam int unsigned POS_W      = 9;
	localparam int unsigned CRC_W      = 16;
	localparam logic [POS_W-1:0] HDR_END = 9'd6;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0]       SYNC_RESET = 8'hFE;

	// one classified byte on its way from the front end to the back end
	typedef struct packed {
		mvl_kind_t          kind;
		logic [7:0]         data;
		mvl_status_t        status;
		logic [POS_W-1:0]   next_pos;
		logic [CRC_W-1:0]   crc;
	} mvl_item_t;

	// one x.25 checksum step over one byte
	function automatic logic [CRC_W-1:0] x25_step(input logic [CRC_W-1:0] crc,
			input logic [7:0] b);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		x25_step = {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
			^ {12'h000, t[7:4]};
	endfunction

endpackage

>>> hw/rtl/mvl_front.sv
module mvl_front
	import mvl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic        in_accept,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_data,
	output mvl_item_t   item
);

	logic [7:0]       sync_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       len_q;
	logic [CRC_W-1:0] crc_q;

	logic [POS_W-1:0] crc_pos;
	logic [CRC_W-1:0] crc_next;
	logic [CRC_W-1:0] crc_stepped;

	assign crc_pos     = {1'b0, len_q} + HDR_END;
	assign crc_stepped = x25_step(crc_q, in_byte);

	// classify the byte by its frame position
	always_comb begin
		item.kind     = KIND_IDLE;
		item.data     = in_byte;
		item.status   = ST_BUSY;
		item.next_pos = '0;
		crc_next      = crc_q;
		if (pos_q == '0) begin
			if (in_byte != sync_q) begin
				item.status = ST_NOSYNC;
			end else begin
				crc_next      = CRC_INIT;
				item.next_pos = 9'd1;
			end
		end else if (pos_q < HDR_END) begin
			case (pos_q)
				9'd1:    item.kind = KIND_LEN;
				9'd2:    item.kind = KIND_SEQ;
				9'd3:    item.kind = KIND_SYS;
				9'd4:    item.kind = KIND_COMP;
				default: item.kind = KIND_MSG;
			endcase
			crc_next      = crc_stepped;
			item.next_pos = pos_q + 9'd1;
		end else if (pos_q < crc_pos) begin
			item.kind     = KIND_PAYLOAD;
			crc_next      = crc_stepped;
			item.next_pos = pos_q + 9'd1;
		end else if (pos_q == crc_pos) begin
			item.kind = KIND_CHECK;
			if (in_byte != crc_q[7:0]) begin
				item.status = ST_BADCRC;
			end else begin
				item.next_pos = pos_q + 9'd1;
			end
		end else begin
			item.kind   = KIND_CHECK;
			item.status = (in_byte != crc_q[15:8]) ? ST_BADCRC : ST_DONE;
		end
		item.crc = crc_next;
	end

	// frame tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			crc_q <= CRC_INIT;
		end else if (in_accept) begin
			pos_q <= item.next_pos;
			crc_q <= crc_next;
			if (item.kind == KIND_LEN) begin
				len_q <= in_byte;
			end
		end
	end

	// sync marker register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_valid) begin
			sync_q <= cfg_data;
		end
	end

	// a sync byte taken while hunting opens a frame
	a_sync_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && pos_q == '0 && in_byte == sync_q) |=> (pos_q == 9'd1 && crc_q == CRC_INIT))
		else $error("sync byte did not open a frame");

	// position never runs past the high checksum byte
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= crc_pos + 9'd1)
		else $error("frame position out of range");

	// an accept always comes with a request
	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> in_valid)
		else $error("accept without request");

endmodule

>>> hw/rtl/mvl_fifo.sv
module mvl_fifo
	import mvl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mvl_item_t wr_item,
	input  logic      pop,
	output mvl_item_t rd_item,
	output logic      full,
	output logic      empty
);

	mvl_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_item = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// no overflow and no underflow
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue overflow or underflow");

endmodule

>>> hw/rtl/mvl_back.sv
module mvl_back
	import mvl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  mvl_item_t    q_item,
	output logic         q_pop,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,
	output logic [2:0]   m_tuser
);

	logic [7:0]       len_q;
	logic [7:0]       seq_q;
	logic [7:0]       sys_q;
	logic [7:0]       comp_q;
	logic [7:0]       msg_q;
	logic [7:0]       len_d;
	logic [7:0]       seq_d;
	logic [7:0]       sys_d;
	logic [7:0]       comp_d;
	logic [7:0]       msg_d;

	logic             out_valid_q;
	mvl_status_t      out_status_q;
	logic [POS_W-1:0] out_pos_q;
	logic [7:0]       out_pbyte_q;
	logic             out_pvalid_q;
	logic [7:0]       out_len_q;
	logic [7:0]       out_seq_q;
	logic [7:0]       out_sys_q;
	logic [7:0]       out_comp_q;
	logic [7:0]       out_msg_q;
	logic [CRC_W-1:0] out_crc_q;

	logic             is_payload;

	assign q_pop      = !q_empty && (!out_valid_q || m_tready);
	assign is_payload = (q_item.kind == KIND_PAYLOAD);

	// header registers after this byte
	always_comb begin
		len_d  = len_q;
		seq_d  = seq_q;
		sys_d  = sys_q;
		comp_d = comp_q;
		msg_d  = msg_q;
		case (q_item.kind)
			KIND_LEN:  len_d  = q_item.data;
			KIND_SEQ:  seq_d  = q_item.data;
			KIND_SYS:  sys_d  = q_item.data;
			KIND_COMP: comp_d = q_item.data;
			KIND_MSG:  msg_d  = q_item.data;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			seq_q  <= '0;
			sys_q  <= '0;
			comp_q <= '0;
			msg_q  <= '0;
		end else if (q_pop) begin
			len_q  <= len_d;
			seq_q  <= seq_d;
			sys_q  <= sys_d;
			comp_q <= comp_d;
			msg_q  <= msg_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_status_q <= q_item.status;
			out_pos_q    <= q_item.next_pos;
			out_pbyte_q  <= is_payload ? q_item.data : 8'h00;
			out_pvalid_q <= is_payload;
			out_len_q    <= len_d;
			out_seq_q    <= seq_d;
			out_sys_q    <= sys_d;
			out_comp_q   <= comp_d;
			out_msg_q    <= msg_d;
			out_crc_q    <= q_item.crc;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_pvalid_q, out_status_q};
	assign m_tdata  = {7'b0000000, out_crc_q, out_msg_q, out_comp_q, out_sys_q,
		out_seq_q, out_len_q, out_pbyte_q, out_pos_q};

	// a payload byte never closes or drops a frame
	a_payload_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_pvalid_q) |-> (out_status_q == ST_BUSY && out_pos_q != '0))
		else $error("payload byte with final status");

	// a finished or failed frame always returns to hunting
	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_BUSY) |-> (out_pos_q == '0))
		else $error("frame end without return to hunting");

endmodule

>>> hw/rtl/mavlink_frame_parser.sv
// mavlink v1 frame parser
//
// input stream: one received serial byte per request on s_tdata[7:0].
// output stream: one result per input byte, in order. m_tuser carries the
// status code and the payload flag, m_tdata the next frame position, the
// payload byte, the header fields and the running x.25 checksum.
// configuration: cfg_valid/cfg_data write the sync marker byte; cfg_ready
// is always high. write it only while no byte is in flight.
// throughput: one byte per cycle while m_tready stays high. the front end
// decides each byte's role and checksum in the cycle it is accepted, a
// two-entry queue holds classified bytes, and the back end updates the
// header registers into an output register.
// path: a taken byte goes through the queue, then the output register.
// reset: hunting for sync, checksum 0xFFFF, header registers zero, sync
// marker 0xFE, queue and output register empty.
// stall: with m_tready low the output register holds; the queue absorbs
// two more bytes, after which s_tready drops until the receiver resumes.
module mavlink_frame_parser
	import mvl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [8:0] next_position, [16:9] payload_byte,
	                               // [24:17] frame_length, [32:25] sequence_res,
	                               // [40:33] system_id, [48:41] component_id,
	                               // [56:49] message_id, [72:57] frame_checksum
	output logic [2:0]  m_tuser,   // [1:0] status, [2] payload_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // [7:0] sync_byte
);

	mvl_item_t front_item;
	mvl_item_t back_item;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;
	logic      in_accept;

	assign s_tready  = !q_full;
	assign in_accept = s_tvalid && !q_full;
	assign cfg_ready = 1'b1;

	// byte classification and checksum
	mvl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_accept (in_accept),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.item      (front_item)
	);

	// decoupling queue
	mvl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_accept),
		.wr_item (front_item),
		.pop     (q_pop),
		.rd_item (back_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	// header capture and result output
	mvl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (back_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mvl_pkg::*;

	// one expected parser result
	typedef struct {
		mvl_status_t status;
		logic [8:0]  next_pos;
		logic [7:0]  pay_byte;
		logic        pay_valid;
		logic [7:0]  len;
		logic [7:0]  seq;
		logic [7:0]  sys_id;
		logic [7:0]  comp_id;
		logic [7:0]  msg_id;
		logic [15:0] crc;
	} parse_result_t;

	// frame parser predictor and result checker
	class frame_scoreboard;
		logic [7:0]    sync;
		logic [8:0]    pos;
		logic [15:0]   crc;
		logic [7:0]    len;
		logic [7:0]    seq;
		logic [7:0]    sys_id;
		logic [7:0]    comp_id;
		logic [7:0]    msg_id;
		parse_result_t pending_q[$];
		int            errors;

		function new();
			sync = 8'hFE;
			pos = '0;
			crc = 16'hFFFF;
			len = '0;
			seq = '0;
			sys_id = '0;
			comp_id = '0;
			msg_id = '0;
			errors = 0;
		endfunction

		// x.25 checksum over one more byte
		static function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
			logic [7:0]  t;
			logic [15:0] wide;
			t = b ^ c[7:0];
			t = t ^ (t << 4);
			wide = {8'h00, t};
			return (c >> 8) ^ (wide << 8) ^ (wide << 3) ^ (wide >> 4);
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function void set_sync(logic [7:0] v);
			sync = v;
		endfunction

		// predict the result of one accepted byte
		function void note_byte(logic [7:0] b);
			parse_result_t r;
			logic [8:0]    check_pos;
			r.status = ST_BUSY;
			r.pay_byte = '0;
			r.pay_valid = 1'b0;
			check_pos = {1'b0, len} + 9'd6;
			if (pos == 9'd0) begin
				if (b != sync) begin
					r.status = ST_NOSYNC;
				end else begin
					crc = 16'hFFFF;
					pos = 9'd1;
				end
			end else if (pos < 9'd6) begin
				case (pos)
					9'd1: len = b;
					9'd2: seq = b;
					9'd3: sys_id = b;
					9'd4: comp_id = b;
					default: msg_id = b;
				endcase
				crc = crc_fold(crc, b);
				pos = pos + 9'd1;
			end else if (pos < check_pos) begin
				r.pay_byte = b;
				r.pay_valid = 1'b1;
				crc = crc_fold(crc, b);
				pos = pos + 9'd1;
			end else if (pos == check_pos) begin
				if (b != crc[7:0]) begin
					r.status = ST_BADCRC;
					pos = 9'd0;
				end else begin
					pos = pos + 9'd1;
				end
			end else begin
				r.status = (b != crc[15:8]) ? ST_BADCRC : ST_DONE;
				pos = 9'd0;
			end
			r.next_pos = pos;
			r.len = len;
			r.seq = seq;
			r.sys_id = sys_id;
			r.comp_id = comp_id;
			r.msg_id = msg_id;
			r.crc = crc;
			pending_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		// check one accepted result against the oldest prediction
		function void check_result(logic [79:0] d, logic [2:0] u);
			parse_result_t r;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
					$time, d, u);
				return;
			end
			r = pending_q.pop_front();
			compare_field("status", 16'(r.status), 16'(u[1:0]));
			compare_field("payload_valid", 16'(r.pay_valid), 16'(u[2]));
			compare_field("next_position", 16'(r.next_pos), 16'(d[8:0]));
			compare_field("payload_byte", 16'(r.pay_byte), 16'(d[16:9]));
			compare_field("frame_length", 16'(r.len), 16'(d[24:17]));
			compare_field("sequence_res", 16'(r.seq), 16'(d[32:25]));
			compare_field("system_id", 16'(r.sys_id), 16'(d[40:33]));
			compare_field("component_id", 16'(r.comp_id), 16'(d[48:41]));
			compare_field("message_id", 16'(r.msg_id), 16'(d[56:49]));
			compare_field("frame_checksum", r.crc, d[72:57]);
		endfunction
	endclass

	localparam int FAULT_NONE  = 0;
	localparam int FAULT_LOW   = 1;
	localparam int FAULT_HIGH  = 2;
	localparam int FAULT_TRUNC = 3;
	localparam int FILL_RANDOM = -1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	frame_scoreboard sb = new();
	int  results_seen = 0;
	int  frame_bytes = 0;
	bit  calm = 1'b0;

	mavlink_frame_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

	// gap length, mostly short, a few long
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one byte request on the input stream
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b);
	endtask

	// build one frame with the current sync marker, optionally damaged
	task automatic send_frame(input int len, input int fault, input int fill);
		logic [7:0]  fb[$];
		logic [15:0] c;
		int          keep;
		fb.push_back(sb.sync);
		fb.push_back(8'(len));
		repeat (4) fb.push_back(8'($urandom));
		for (int i = 0; i < len; i++)
			fb.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
		c = 16'hFFFF;
		for (int i = 1; i < fb.size(); i++)
			c = frame_scoreboard::crc_fold(c, fb[i]);
		fb.push_back(c[7:0]);
		fb.push_back(c[15:8]);
		case (fault)
			FAULT_LOW: begin
				fb[fb.size()-2] = fb[fb.size()-2] ^ 8'($urandom_range(1, 255));
				void'(fb.pop_back());
			end
			FAULT_HIGH: begin
				fb[fb.size()-1] = fb[fb.size()-1] ^ 8'($urandom_range(1, 255));
			end
			FAULT_TRUNC: begin
				keep = $urandom_range(1, fb.size() - 2);
				while (fb.size() > keep) void'(fb.pop_back());
			end
			default: ;
		endcase
		frame_bytes += fb.size();
		foreach (fb[i]) send_byte(fb[i]);
	endtask

	// drain results, then write the sync marker
	task automatic write_sync(input logic [7:0] v);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_sync(v);
	endtask

	// random mix of frames, damaged frames and line noise
	task automatic random_traffic(input int target);
		int r;
		int len;
		int stop_at;
		stop_at = frame_bytes + target;
		while (frame_bytes < stop_at) begin
			r = $urandom_range(0, 99);
			len = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 255)
				: $urandom_range(0, 12);
			if (r < 70) begin
				send_frame(len, FAULT_NONE, FILL_RANDOM);
			end else if (r < 78) begin
				send_frame(len, FAULT_LOW, FILL_RANDOM);
			end else if (r < 86) begin
				send_frame(len, FAULT_HIGH, FILL_RANDOM);
			end else if (r < 92) begin
				send_frame(len, FAULT_TRUNC, FILL_RANDOM);
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end
		end
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tuser);
			results_seen++;
		end
	end

	// receiver readiness, with two long hold-offs to back up the input
	initial begin
		int  on_len;
		int  off_len;
		bit  held_a;
		bit  held_b;
		held_a = 1'b0;
		held_b = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ((!held_a && results_seen >= 200) || (!held_b && results_seen >= 800)) begin
				if (results_seen >= 800) held_b = 1'b1;
				held_a = 1'b1;
				m_tready <= 1'b0;
				repeat (120) @(posedge clk);
			end
			on_len = $urandom_range(1, 20);
			m_tready <= 1'b1;
			repeat (on_len) @(posedge clk);
			off_len = pick_gap();
			if (off_len > 0) begin
				m_tready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise while hunting, empty frame, sync marker as payload,
		// bad low checksum byte
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(0, FAULT_NONE, FILL_RANDOM);
		send_frame(1, FAULT_NONE, 8'hFE);
		send_frame(0, FAULT_LOW, FILL_RANDOM);
		random_traffic(100);

		write_sync(8'h00);
		calm = 1'b1;
		send_frame(3, FAULT_NONE, 8'h00);
		random_traffic(100);
		calm = 1'b0;

		// largest frame with all-ones marker
		write_sync(8'hFF);
		send_frame(255, FAULT_NONE, 8'hFF);
		send_frame(255, FAULT_HIGH, FILL_RANDOM);
		random_traffic(80);

		write_sync(8'h55);
		random_traffic(120);

		write_sync(8'($urandom));
		random_traffic(120);

		write_sync(8'hFE);
		random_traffic(60);

		// drain and settle
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> mavlink_frame_parser.f
hw/rtl/mvl_pkg.sv
hw/rtl/mvl_front.sv
hw/rtl/mvl_fifo.sv
hw/rtl/mvl_back.sv
hw/rtl/mavlink_frame_parser.sv
dv/tb.sv
